[hdl/fsh_pkg.sv]
package fsh_pkg;

	// Command codes carried by each request.
	localparam logic [1:0] CMD_DATA     = 2'd0;
	localparam logic [1:0] CMD_READ     = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;
	localparam logic [1:0] CMD_EV_CLEAR = 2'd3;

	// Configuration register indexes.
	localparam logic REG_COUNT_LIMIT = 1'b0;
	localparam logic REG_SCALE_START = 1'b1;

	// Default histogram depth and reset values.
	localparam int unsigned         NUM_BINS_DEF = 1024;
	localparam logic [15:0]         RESET_LIMIT  = 16'd64000;
	localparam logic [15:0]         RESET_SCALE  = 16'd1000;
	localparam logic [7:0]          MARKER_BYTE  = 8'hFF;
	localparam logic [2:0]          MARKER_LEN   = 3'd4;
	localparam logic [31:0]         EVENT_MAX    = 32'hFFFF_FFFF;

	typedef logic [15:0] bin_count_t;

endpackage

[hdl/framed_sample_histogrammer.sv]
// Framed sample histogrammer. Data bytes (cmd 0) are scanned for a marker of four 0xFF bytes,
// which sets word alignment; after it, byte pairs (low byte first) form a 16-bit word that is
// shifted right by two and, when below NUM_BINS, increments that bin of an on-chip histogram.
// A bin already at or above count_limit sets the halted flag and further data bytes are ignored
// until a clear. Other commands read a bin (cmd 1), clear the histogram and the acquisition state
// (cmd 2), or return and zero the event counter (cmd 3). Every request yields one result.
// On accept the request issues the histogram read; the execute step then waits until the result
// register is free or out_ready is high, completes the read-modify-write through the bin memory,
// and loads the result, which may then wait for out_ready while the next request is accepted.
// After reset, and after every clear command, the block sweeps the memory to zero, one bin per
// cycle over every bin, during which in_ready is low; configuration writes are always taken.
module framed_sample_histogrammer
	import fsh_pkg::*;
#(
	parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  bin_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        counted,
	output logic [9:0]  bin_index,
	output logic [15:0] bin_count,
	output logic        halted,
	output logic        synced,
	output logic [16:0] scale,
	output logic [31:0] event_total
);

	localparam int unsigned ADDR_W = $clog2(NUM_BINS);
	localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(NUM_BINS - 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	// Control and acquisition state.
	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [15:0]       count_limit_q;
	logic [15:0]       scale_start_q;
	logic [2:0]        run_q;
	logic              sync_q;
	logic              phase_q;
	logic [7:0]        hold_q;
	logic              stop_q;
	logic [16:0]       scale_q;
	logic [31:0]       event_q;

	// Request held for the execute cycle.
	logic [1:0]  cmd_s1;
	logic [7:0]  byte_s1;
	logic [13:0] idx_s1;
	logic        in_range_s1;

	// Histogram memory and its registered read data.
	bin_count_t        mem [NUM_BINS];
	bin_count_t        rd_data_q;

	// Result register.
	logic        out_valid_q;
	logic        counted_q;
	logic [9:0]  bin_index_q;
	logic [15:0] bin_count_q;
	logic [31:0] event_total_q;

	// Combinational signals.
	logic              accept;
	logic              out_take;
	logic [13:0]       word_in;
	logic [13:0]       sel_idx;
	logic [15:0]       sel_ext;
	logic [15:0]       wr_ext;
	logic              sel_in_range;
	logic [16:0]       h_inc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	bin_count_t        mem_wdata;
	logic [2:0]        nxt_run;
	logic              nxt_sync;
	logic              nxt_phase;
	logic [7:0]        nxt_hold;
	logic              nxt_stop;
	logic [16:0]       nxt_scale;
	logic [31:0]       nxt_event;
	logic              res_counted;
	logic [9:0]        res_idx;
	logic [15:0]       res_cnt;
	logic [31:0]       res_ev;
	logic              do_inc;

	// Handshake.
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_take = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// Bin addressed by the request: the word a high byte would complete, or the read address.
	assign word_in      = {data_byte, hold_q[7:2]};
	assign sel_idx      = (cmd == CMD_READ) ? {4'b0, bin_addr} : word_in;
	assign sel_ext      = {2'b0, sel_idx};
	assign sel_in_range = ({3'b0, sel_idx} < 17'(NUM_BINS));
	assign wr_ext       = {2'b0, idx_s1};
	assign h_inc        = {1'b0, rd_data_q} + 17'd1;

	// Execute step: next acquisition state and the result fields.
	always_comb begin
		nxt_run     = run_q;
		nxt_sync    = sync_q;
		nxt_phase   = phase_q;
		nxt_hold    = hold_q;
		nxt_stop    = stop_q;
		nxt_scale   = scale_q;
		nxt_event   = event_q;
		res_counted = 1'b0;
		res_idx     = 10'd0;
		res_cnt     = 16'd0;
		res_ev      = event_q;
		do_inc      = 1'b0;
		case (cmd_s1)
			CMD_DATA: begin
				if (!stop_q) begin
					if (sync_q) begin
						if (!phase_q) begin
							nxt_hold  = byte_s1;
							nxt_phase = 1'b1;
						end else begin
							nxt_phase = 1'b0;
							if (in_range_s1) begin
								res_idx = idx_s1[9:0];
								if (rd_data_q >= count_limit_q) begin
									nxt_stop = 1'b1;
									res_cnt  = rd_data_q;
								end else begin
									do_inc      = 1'b1;
									res_cnt     = h_inc[15:0];
									res_counted = 1'b1;
									if (h_inc > scale_q) begin
										nxt_scale = {scale_q[15:0], 1'b0};
									end
									if (event_q != EVENT_MAX) begin
										nxt_event = event_q + 32'd1;
									end
								end
							end
						end
					end
					// Marker tracking comes after the byte is used as data.
					if (byte_s1 == MARKER_BYTE) begin
						nxt_run = run_q + 3'd1;
						if (nxt_run >= MARKER_LEN) begin
							nxt_run   = 3'd0;
							nxt_sync  = 1'b1;
							nxt_phase = 1'b0;
						end
					end else begin
						nxt_run = 3'd0;
					end
				end
				res_ev = nxt_event;
			end
			CMD_READ: begin
				res_idx = idx_s1[9:0];
				res_cnt = in_range_s1 ? rd_data_q : 16'd0;
			end
			CMD_CLEAR: begin
				nxt_run   = 3'd0;
				nxt_sync  = 1'b0;
				nxt_phase = 1'b0;
				nxt_hold  = 8'd0;
				nxt_stop  = 1'b0;
				nxt_scale = {1'b0, scale_start_q};
			end
			CMD_EV_CLEAR: begin
				nxt_event = 32'd0;
			end
			default: begin
				nxt_run = run_q;
			end
		endcase
	end

	// Memory write: zeroing sweep, or the incremented bin.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = out_take && do_inc;
			mem_waddr = wr_ext[ADDR_W-1:0];
			mem_wdata = h_inc[15:0];
		end
	end

	// Histogram memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_data_q <= mem[sel_ext[ADDR_W-1:0]];
		end
	end

	// Request registers for the execute cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			byte_s1     <= data_byte;
			idx_s1      <= sel_idx;
			in_range_s1 <= sel_in_range;
		end
	end

	// Sequencer, acquisition state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			count_limit_q <= RESET_LIMIT;
			scale_start_q <= RESET_SCALE;
			run_q         <= 3'd0;
			sync_q        <= 1'b0;
			phase_q       <= 1'b0;
			hold_q        <= 8'd0;
			stop_q        <= 1'b0;
			scale_q       <= {1'b0, RESET_SCALE};
			event_q       <= 32'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_COUNT_LIMIT) begin
					count_limit_q <= cfg_wdata;
				end else begin
					scale_start_q <= cfg_wdata;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_BIN) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_take) begin
						run_q   <= nxt_run;
						sync_q  <= nxt_sync;
						phase_q <= nxt_phase;
						hold_q  <= nxt_hold;
						stop_q  <= nxt_stop;
						scale_q <= nxt_scale;
						event_q <= nxt_event;
						state_q <= (cmd_s1 == CMD_CLEAR) ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_take) begin
			counted_q     <= res_counted;
			bin_index_q   <= res_idx;
			bin_count_q   <= res_cnt;
			event_total_q <= res_ev;
		end
	end

	assign out_valid   = out_valid_q;
	assign counted     = counted_q;
	assign bin_index   = bin_index_q;
	assign bin_count   = bin_count_q;
	assign halted      = stop_q;
	assign synced      = sync_q;
	assign scale       = scale_q;
	assign event_total = event_total_q;

`ifndef NO_ASSERTIONS
	// A clear command that completes starts a sweep from the first bin.
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && (cmd_s1 == CMD_CLEAR) |=> (state_q == ST_CLEAR) && (clr_q == '0))
		else $error("clear command did not start a sweep");

	// The sweep counter rests at zero outside the sweep.
	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> (clr_q == '0))
		else $error("sweep counter not at zero outside the sweep");

	// A counted word always leaves a non-zero bin.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && counted |-> (bin_count != 16'd0))
		else $error("counted result with an empty bin");

	// A word can only be counted while aligned and not stopped.
	a_count_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && res_counted |=> synced && !halted)
		else $error("word counted while stopped or unaligned");
`endif

endmodule
